/* rtl/core/lcats_pkg.sv */
// Shared types, constants and width helpers for the load-cell averaging block.
// Used by every module in rtl/core; depends on nothing else.
package lcats_pkg;

  localparam int RAW_W     = 24;
  localparam int OFS_W     = 24;
  localparam int SCALE_W   = 32;
  localparam int MAXMG_W   = 16;
  localparam int WEIGHT_W  = 24;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam int MEASURE_SAMPLES_DEF = 16;
  localparam int TARE_SAMPLES_DEF    = 32;
  localparam int SAMPLE_BITS_DEF     = 24;

  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd65536;
  localparam logic [MAXMG_W-1:0] MAXMG_RST = 16'd5000;

  localparam logic [1:0] REQ_MEASURE = 2'd0;
  localparam logic [1:0] REQ_TARE    = 2'd1;
  localparam logic [1:0] REQ_LOAD    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXMG = 1'd1;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_TARE   = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [OFS_W-1:0] offset;
  } blk_tag_t;

  typedef struct packed {
    logic                    busy;
    logic                    wr;
    logic signed [OFS_W-1:0] value;
  } ofs_upd_t;

  function automatic int samp_w(input int sample_bits);
    return (sample_bits > RAW_W) ? RAW_W + 1 : RAW_W;
  endfunction

  function automatic int max_n(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int mag_w(input int sample_bits, input int nm, input int nt);
    return samp_w(sample_bits) + $clog2(max_n(nm, nt));
  endfunction

  function automatic int cnt_w(input int nm, input int nt);
    return $clog2(max_n(nm, nt) + 1);
  endfunction

endpackage

/* rtl/core/lcats_accum.sv */
// Input stage: sample selection, block accumulation, mode and offset state.
// Hands each finished block sum to the divider; depends on lcats_pkg.
module lcats_accum #(
  parameter int MEASURE_SAMPLES = lcats_pkg::MEASURE_SAMPLES_DEF,
  parameter int TARE_SAMPLES    = lcats_pkg::TARE_SAMPLES_DEF,
  parameter int SAMPLE_BITS     = lcats_pkg::SAMPLE_BITS_DEF,
  localparam int ACC_W = lcats_pkg::mag_w(SAMPLE_BITS, MEASURE_SAMPLES, TARE_SAMPLES) + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic [lcats_pkg::RAW_W-1:0]         raw_sample,
  input  logic                                no_data,
  input  logic signed [lcats_pkg::OFS_W-1:0]  offset_in,
  input  lcats_pkg::ofs_upd_t                 upd,
  output logic                                blk_valid,
  input  logic                                blk_ready,
  output logic signed [ACC_W-1:0]             blk_sum,
  output lcats_pkg::blk_tag_t                 blk_tag
);

  localparam int SW    = lcats_pkg::samp_w(SAMPLE_BITS);
  localparam int SH    = (SAMPLE_BITS < SW) ? SW - SAMPLE_BITS : 0;
  localparam int CNT_W = lcats_pkg::cnt_w(MEASURE_SAMPLES, TARE_SAMPLES);
  localparam logic [CNT_W-1:0] NEED_M = CNT_W'(MEASURE_SAMPLES);
  localparam logic [CNT_W-1:0] NEED_T = CNT_W'(TARE_SAMPLES);

  logic signed [ACC_W-1:0]            acc;
  logic [CNT_W-1:0]                   cnt;
  logic                               mode;
  logic signed [lcats_pkg::OFS_W-1:0] offset_value;

  logic [SW-1:0]           raw_zx;
  logic signed [SW-1:0]    raw_shl;
  logic signed [SW-1:0]    raw_ext;
  logic signed [SW-1:0]    sample;
  logic                    restart;
  logic                    is_sample;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] sum;
  logic [CNT_W-1:0]        cnt_base;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        need;
  logic                    done;
  logic                    hold;
  logic                    take;
  logic                    blk_load;

  // The converter word is sign-extended from its configured width.
  assign raw_zx  = SW'(raw_sample);
  assign raw_shl = $signed(raw_zx << SH);
  assign raw_ext = raw_shl >>> SH;
  assign sample  = no_data ? SW'(offset_value) : raw_ext;

  assign restart   = (req_type[0] != mode);
  assign is_sample = req_type inside {lcats_pkg::REQ_MEASURE, lcats_pkg::REQ_TARE};
  assign acc_base  = restart ? '0 : acc;
  assign cnt_base  = restart ? '0 : cnt;
  assign sum       = acc_base + ACC_W'(sample);
  assign cnt_inc   = cnt_base + CNT_W'(1);
  assign need      = req_type[0] ? NEED_T : NEED_M;
  assign done      = (cnt_inc == need);

  // A tare block in flight holds the input until its offset has been written.
  assign hold     = upd.busy || (blk_valid && (blk_tag.kind == lcats_pkg::KIND_TARE));
  assign in_ready = !hold && (!blk_valid || blk_ready);
  assign take     = in_valid && in_ready;
  assign blk_load = take && is_sample && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      cnt          <= '0;
      mode         <= lcats_pkg::KIND_WEIGHT;
      offset_value <= '0;
      blk_valid    <= 1'b0;
    end else begin
      if (upd.wr) begin
        offset_value <= upd.value;
      end
      if (take) begin
        case (req_type)
          lcats_pkg::REQ_MEASURE, lcats_pkg::REQ_TARE: begin
            mode <= req_type[0];
            if (done) begin
              acc <= '0;
              cnt <= '0;
            end else begin
              acc <= sum;
              cnt <= cnt_inc;
            end
          end
          lcats_pkg::REQ_LOAD: begin
            offset_value <= offset_in;
            acc          <= '0;
            cnt          <= '0;
          end
          default: begin
          end
        endcase
      end
      if (blk_load) begin
        blk_valid <= 1'b1;
      end else if (blk_ready) begin
        blk_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_load) begin
      blk_sum        <= sum;
      blk_tag.kind   <= req_type[0];
      blk_tag.offset <= offset_value;
    end
  end

endmodule

/* rtl/core/lcats_div.sv */
// Block mean: magnitude, reciprocal multiply and sign restore, truncating toward zero.
// Writes a finished tare mean back as the new offset; depends on lcats_pkg.
module lcats_div #(
  parameter int MEASURE_SAMPLES = lcats_pkg::MEASURE_SAMPLES_DEF,
  parameter int TARE_SAMPLES    = lcats_pkg::TARE_SAMPLES_DEF,
  parameter int SAMPLE_BITS     = lcats_pkg::SAMPLE_BITS_DEF,
  localparam int MAG_W = lcats_pkg::mag_w(SAMPLE_BITS, MEASURE_SAMPLES, TARE_SAMPLES),
  localparam int ACC_W = MAG_W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [ACC_W-1:0] up_sum,
  input  lcats_pkg::blk_tag_t     up_tag,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [MAG_W:0]   dn_avg,
  output lcats_pkg::blk_tag_t     dn_tag,
  output lcats_pkg::ofs_upd_t     upd
);

  localparam int NMAX  = lcats_pkg::max_n(MEASURE_SAMPLES, TARE_SAMPLES);
  localparam int DIV_S = MAG_W + $clog2(NMAX);
  localparam longint unsigned RECIP_M =
    ((64'd1 << DIV_S) + 64'(MEASURE_SAMPLES) - 64'd1) / 64'(MEASURE_SAMPLES);
  localparam longint unsigned RECIP_T =
    ((64'd1 << DIV_S) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES);
  localparam longint unsigned RECIP_MAX = (RECIP_M > RECIP_T) ? RECIP_M : RECIP_T;
  localparam int M_W  = $clog2(RECIP_MAX + 64'd1);
  localparam int PW   = MAG_W + M_W;
  localparam logic [M_W-1:0] RM_C = M_W'(RECIP_M);
  localparam logic [M_W-1:0] RT_C = M_W'(RECIP_T);

  logic                v2;
  logic [MAG_W-1:0]    mag2;
  logic                neg2;
  lcats_pkg::blk_tag_t tag2;

  logic                v3;
  logic [PW-1:0]       prod3;
  logic                neg3;
  lcats_pkg::blk_tag_t tag3;

  logic                r2;
  logic                r3;
  logic                r4;
  logic [MAG_W-1:0]    mag_n;
  logic [M_W-1:0]      recip;
  logic [MAG_W-1:0]    quo;
  logic signed [MAG_W:0] quo_s;
  logic signed [MAG_W:0] avg_n;
  logic                tare3;

  assign r4       = !dn_valid || dn_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign up_ready = r2;

  assign mag_n = up_sum[ACC_W-1] ? MAG_W'(-up_sum) : MAG_W'(up_sum);
  assign recip = (tag2.kind == lcats_pkg::KIND_TARE) ? RT_C : RM_C;
  assign quo   = MAG_W'(prod3 >> DIV_S);
  assign quo_s = $signed({1'b0, quo});
  assign avg_n = neg3 ? -quo_s : quo_s;
  assign tare3 = (tag3.kind == lcats_pkg::KIND_TARE);

  always_comb begin
    upd.busy  = (v2 && (tag2.kind == lcats_pkg::KIND_TARE)) || (v3 && tare3);
    upd.wr    = v3 && r4 && tare3;
    upd.value = avg_n[lcats_pkg::OFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      v3       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (r2) begin
        v2 <= up_valid;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        dn_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && up_valid) begin
      mag2 <= mag_n;
      neg2 <= up_sum[ACC_W-1];
      tag2 <= up_tag;
    end
    if (r3 && v2) begin
      prod3 <= PW'(mag2) * PW'(recip);
      neg3  <= neg2;
      tag3  <= tag2;
    end
    if (r4 && v3) begin
      dn_avg      <= avg_n;
      dn_tag.kind <= tag3.kind;
      dn_tag.offset <= tare3 ? avg_n[lcats_pkg::OFS_W-1:0] : tag3.offset;
    end
  end

endmodule

/* rtl/core/lcats_scale.sv */
// Tare subtraction, Q16.16 scaling and clamping to the reported weight range.
// Ends in the output register of the block; depends on lcats_pkg.
module lcats_scale #(
  parameter int MEASURE_SAMPLES = lcats_pkg::MEASURE_SAMPLES_DEF,
  parameter int TARE_SAMPLES    = lcats_pkg::TARE_SAMPLES_DEF,
  parameter int SAMPLE_BITS     = lcats_pkg::SAMPLE_BITS_DEF,
  localparam int MAG_W = lcats_pkg::mag_w(SAMPLE_BITS, MEASURE_SAMPLES, TARE_SAMPLES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [MAG_W:0]               up_avg,
  input  lcats_pkg::blk_tag_t                 up_tag,
  input  logic [lcats_pkg::SCALE_W-1:0]       scale_q16,
  input  logic [lcats_pkg::MAXMG_W-1:0]       max_mg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                result_kind,
  output logic [lcats_pkg::WEIGHT_W-1:0]      weight_q8,
  output logic signed [lcats_pkg::OFS_W-1:0]  new_offset,
  output logic                                clamped_low,
  output logic                                clamped_high
);

  localparam int SW     = lcats_pkg::samp_w(SAMPLE_BITS);
  localparam int DIFF_W = MAG_W + 2;
  localparam int PROD_W = SW + lcats_pkg::SCALE_W;

  logic                v5;
  logic [SW-1:0]       d5;
  logic                nz5;
  logic                lo5;
  lcats_pkg::blk_tag_t tag5;

  logic                v6;
  logic [PROD_W-1:0]   p6;
  logic                nz6;
  logic                lo6;
  lcats_pkg::blk_tag_t tag6;

  logic                     r5;
  logic                     r6;
  logic                     ro;
  logic signed [DIFF_W-1:0] diff;
  logic                     scale_nz;
  logic [PROD_W-1:0]        limit;
  logic                     hi;
  logic [lcats_pkg::WEIGHT_W-1:0] w;
  logic                     tare6;

  assign ro       = !out_valid || out_ready;
  assign r6       = !v6 || ro;
  assign r5       = !v5 || r6;
  assign up_ready = r5;

  assign diff     = DIFF_W'(up_avg) - DIFF_W'(up_tag.offset);
  assign scale_nz = (scale_q16 != '0);

  // A product exactly at the limit passes without the high flag.
  assign limit = PROD_W'({max_mg, 16'b0});
  assign hi    = nz6 && (p6 > limit);
  assign tare6 = (tag6.kind == lcats_pkg::KIND_TARE);

  always_comb begin
    if (!nz6) begin
      w = '0;
    end else if (hi) begin
      w = {max_mg, 8'b0};
    end else begin
      w = lcats_pkg::WEIGHT_W'(p6 >> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r5) begin
        v5 <= up_valid;
      end
      if (r6) begin
        v6 <= v5;
      end
      if (ro) begin
        out_valid <= v6;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r5 && up_valid) begin
      d5   <= diff[SW-1:0];
      nz5  <= !diff[DIFF_W-1] && (diff != '0) && scale_nz;
      lo5  <= diff[DIFF_W-1] && scale_nz;
      tag5 <= up_tag;
    end
    if (r6 && v5) begin
      p6   <= PROD_W'(d5) * PROD_W'(scale_q16);
      nz6  <= nz5;
      lo6  <= lo5;
      tag6 <= tag5;
    end
    if (ro && v6) begin
      result_kind  <= tag6.kind;
      new_offset   <= tag6.offset;
      weight_q8    <= tare6 ? '0 : w;
      clamped_low  <= !tare6 && lo6;
      clamped_high <= !tare6 && hi;
    end
  end

endmodule

/* rtl/core/load_cell_average_tare_scale.sv */
// Top level of the load-cell averager: configuration registers and the three stages.
// Instantiates lcats_accum, lcats_div and lcats_scale; depends on lcats_pkg.
//
// The block takes one converter word per clock cycle while in_ready is high. A word that completes a measure
// block gives its weight after passing the divider's reciprocal multiply and the scale multiply,
// each with its own register. A word that completes a tare block holds in_ready low until
// the new offset leaves the divider and is written back; all other words, offset loads and
// ignored requests follow back to back. A waiting output word does not stop the input while
// pipeline slots remain.
module load_cell_average_tare_scale #(
  parameter int MEASURE_SAMPLES = lcats_pkg::MEASURE_SAMPLES_DEF,
  parameter int TARE_SAMPLES    = lcats_pkg::TARE_SAMPLES_DEF,
  parameter int SAMPLE_BITS     = lcats_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           req_type,
  input  logic [lcats_pkg::RAW_W-1:0]          raw_sample,
  input  logic                                 no_data,
  input  logic signed [lcats_pkg::OFS_W-1:0]   offset_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 result_kind,
  output logic [lcats_pkg::WEIGHT_W-1:0]       weight_q8,
  output logic signed [lcats_pkg::OFS_W-1:0]   new_offset,
  output logic                                 clamped_low,
  output logic                                 clamped_high,
  input  logic                                 cfg_we,
  input  logic [lcats_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcats_pkg::CFG_W-1:0]          cfg_data
);

  localparam int MAG_W = lcats_pkg::mag_w(SAMPLE_BITS, MEASURE_SAMPLES, TARE_SAMPLES);
  localparam int ACC_W = MAG_W + 1;

  logic [lcats_pkg::SCALE_W-1:0] scale_q16;
  logic [lcats_pkg::MAXMG_W-1:0] max_mg;

  logic                    blk_valid;
  logic                    blk_ready;
  logic signed [ACC_W-1:0] blk_sum;
  lcats_pkg::blk_tag_t     blk_tag;
  lcats_pkg::ofs_upd_t     upd;
  logic                    avg_valid;
  logic                    avg_ready;
  logic signed [MAG_W:0]   avg;
  lcats_pkg::blk_tag_t     avg_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q16 <= lcats_pkg::SCALE_RST;
      max_mg    <= lcats_pkg::MAXMG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcats_pkg::CFG_SCALE: scale_q16 <= cfg_data;
        lcats_pkg::CFG_MAXMG: max_mg    <= cfg_data[lcats_pkg::MAXMG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lcats_accum #(
    .MEASURE_SAMPLES (MEASURE_SAMPLES),
    .TARE_SAMPLES    (TARE_SAMPLES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .raw_sample (raw_sample),
    .no_data    (no_data),
    .offset_in  (offset_in),
    .upd        (upd),
    .blk_valid  (blk_valid),
    .blk_ready  (blk_ready),
    .blk_sum    (blk_sum),
    .blk_tag    (blk_tag)
  );

  lcats_div #(
    .MEASURE_SAMPLES (MEASURE_SAMPLES),
    .TARE_SAMPLES    (TARE_SAMPLES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (blk_valid),
    .up_ready (blk_ready),
    .up_sum   (blk_sum),
    .up_tag   (blk_tag),
    .dn_valid (avg_valid),
    .dn_ready (avg_ready),
    .dn_avg   (avg),
    .dn_tag   (avg_tag),
    .upd      (upd)
  );

  lcats_scale #(
    .MEASURE_SAMPLES (MEASURE_SAMPLES),
    .TARE_SAMPLES    (TARE_SAMPLES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (avg_valid),
    .up_ready     (avg_ready),
    .up_avg       (avg),
    .up_tag       (avg_tag),
    .scale_q16    (scale_q16),
    .max_mg       (max_mg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .weight_q8    (weight_q8),
    .new_offset   (new_offset),
    .clamped_low  (clamped_low),
    .clamped_high (clamped_high)
  );

endmodule

/* rtl/core/lcats_check.sv */
// Port-level checker for the load-cell averager, bound to the top level.
// Watches only the output channel and reset; depends on lcats_pkg.
module lcats_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            result_kind,
  input logic [lcats_pkg::WEIGHT_W-1:0]  weight_q8,
  input logic                            clamped_low,
  input logic                            clamped_high
);

  // A tare word carries no weight and no clamp flags.
  a_tare_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == lcats_pkg::KIND_TARE) |->
      (weight_q8 == '0) && !clamped_low && !clamped_high)
    else $error("tare word with weight or flags");

  // A low clamp forces the weight to zero and is never also flagged high.
  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped_low |-> (weight_q8 == '0) && !clamped_high)
    else $error("low clamp with nonzero weight or high flag");

  // No word is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(weight_q8) && $stable(result_kind))
    else $error("output word changed while stalled");

endmodule

bind load_cell_average_tare_scale lcats_check u_check (.*);
